// File: rtl/core/cpp_pkg.sv
// ----------------------------------------------------------------------------
// cpp_pkg
// Shared types and constants for the cursor pixel plotter: payload structs,
// register map and reset values.
// ----------------------------------------------------------------------------
package cpp_pkg;

    localparam int CPP_PAGES   = 8;
    localparam int CPP_COLUMNS = 128;

    localparam int CPP_APB_ADDR_W = 5;
    localparam int CPP_APB_DATA_W = 32;

    localparam logic [7:0] CPP_COLUMN_OFFSET_RST = 8'd30;
    localparam logic [7:0] CPP_PAGE_BASE_RST     = 8'd176;
    localparam logic [7:0] CPP_COL_LOW_BASE_RST  = 8'd0;
    localparam logic [7:0] CPP_COL_HIGH_BASE_RST = 8'd16;
    localparam logic [5:0] CPP_START_ROW_RST     = 6'd32;
    localparam logic [6:0] CPP_START_COLUMN_RST  = 7'd64;

    typedef enum logic [2:0] {
        REG_COLUMN_OFFSET     = 3'd0,
        REG_PAGE_BASE         = 3'd1,
        REG_COL_LOW_BASE      = 3'd2,
        REG_COL_HIGH_BASE     = 3'd3,
        REG_START_ROW         = 3'd4,
        REG_START_COLUMN      = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic up_pressed;
        logic down_pressed;
        logic left_pressed;
        logic right_pressed;
    } t_in_item;

    typedef struct packed {
        logic       is_data;
        logic [7:0] lcd_byte;
        logic       last;
    } t_out_item;

endpackage

// File: rtl/core/cursor_pixel_plotter_top.sv
// ----------------------------------------------------------------------------
// cursor_pixel_plotter_top
// Sketch-pad plotter for a paged monochrome LCD.
//
// Input channel: one button event per transfer (up/down/left/right, any mix).
// The cursor moves with wrap, its pixel is ORed into the frame store, and
// four LCD bytes go out on the output channel: page command, column low and
// column high commands, then the data byte (is_data and last set).
// The event is registered in s1, its four bytes in pend, then moved to seq for output.
// The four output transfers per event bound the event rate; a second event
// is taken while the previous run is still draining.
// The frame store RAM is read, and written back in the next cycle; a new event
// is taken only after the previous write-back, so no read sees stale data.
// Reset: registers and cursor load defaults, then a clearing pass zeroes the
// frame store, all PAGES*COLUMNS entries (1024 by default), with o_in_ready low.
// APB writes are taken at any time. A stalled receiver holds the current
// byte; input is then held off once one finished run waits behind it.
// ----------------------------------------------------------------------------
module cursor_pixel_plotter_top
    import cpp_pkg::*;
#(
    parameter int PAGES   = CPP_PAGES,
    parameter int COLUMNS = CPP_COLUMNS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  t_in_item                  i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output t_out_item                 o_out_data,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [CPP_APB_ADDR_W-1:0] paddr,
    input  logic [CPP_APB_DATA_W-1:0] pwdata,
    output logic [CPP_APB_DATA_W-1:0] prdata,
    output logic                      pready
);

    localparam int ROWS   = PAGES * 8;
    localparam int DEPTH  = PAGES * COLUMNS;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic [ROW_W-1:0]  ROW_MAX  = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  COL_MAX  = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  ROW_RST  = ROW_W'(int'(CPP_START_ROW_RST) % ROWS);
    localparam logic [COL_W-1:0]  COL_RST  = COL_W'(int'(CPP_START_COLUMN_RST) % COLUMNS);
    localparam logic [ADDR_W-1:0] COLS_A   = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] ADDR_MAX = ADDR_W'(DEPTH - 1);

    // configuration registers
    logic [7:0] r_column_offset;
    logic [7:0] r_page_base;
    logic [7:0] r_col_low_base;
    logic [7:0] r_col_high_base;
    logic [5:0] r_start_row;
    logic [6:0] r_start_column;

    logic     cfg_wr;
    t_reg_idx cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column_offset <= CPP_COLUMN_OFFSET_RST;
            r_page_base     <= CPP_PAGE_BASE_RST;
            r_col_low_base  <= CPP_COL_LOW_BASE_RST;
            r_col_high_base <= CPP_COL_HIGH_BASE_RST;
            r_start_row     <= CPP_START_ROW_RST;
            r_start_column  <= CPP_START_COLUMN_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_COLUMN_OFFSET: r_column_offset <= pwdata[7:0];
                REG_PAGE_BASE:     r_page_base     <= pwdata[7:0];
                REG_COL_LOW_BASE:  r_col_low_base  <= pwdata[7:0];
                REG_COL_HIGH_BASE: r_col_high_base <= pwdata[7:0];
                REG_START_ROW:     r_start_row     <= pwdata[5:0];
                REG_START_COLUMN:  r_start_column  <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_COLUMN_OFFSET: prdata = CPP_APB_DATA_W'(r_column_offset);
            REG_PAGE_BASE:     prdata = CPP_APB_DATA_W'(r_page_base);
            REG_COL_LOW_BASE:  prdata = CPP_APB_DATA_W'(r_col_low_base);
            REG_COL_HIGH_BASE: prdata = CPP_APB_DATA_W'(r_col_high_base);
            REG_START_ROW:     prdata = CPP_APB_DATA_W'(r_start_row);
            REG_START_COLUMN:  prdata = CPP_APB_DATA_W'(r_start_column);
            default:           prdata = '0;
        endcase
    end

    // control state
    logic              r_clr_active;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_col;
    logic              r_s1_valid;
    logic              r_pend_valid;
    logic              r_seq_valid;
    logic [1:0]        r_seq_cnt;

    // payload
    logic [ADDR_W-1:0] r_s1_idx;
    logic [2:0]        r_s1_bit;
    logic [PAGE_W-1:0] r_s1_page;
    logic [7:0]        r_s1_addr;
    logic [7:0]        r_pend_bytes [4];
    logic [7:0]        r_seq_bytes  [4];

    logic              in_xfer;
    logic              out_xfer;
    logic              seq_free;
    logic              pend_move;
    logic [ROW_W-1:0]  n_row;
    logic [COL_W-1:0]  n_col;
    logic [PAGE_W-1:0] n_page;
    logic [ADDR_W-1:0] n_idx;
    logic [7:0]        ram_rdata;
    logic [7:0]        s1_data;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;

    // one event in the read-modify-write path at a time
    assign o_in_ready = !r_clr_active && !r_s1_valid && !r_pend_valid;
    assign in_xfer    = i_in_valid && o_in_ready;
    assign out_xfer   = r_seq_valid && i_out_ready;
    assign seq_free   = !r_seq_valid || (out_xfer && (r_seq_cnt == 2'd3));
    assign pend_move  = r_pend_valid && seq_free;

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (i_in_data.up_pressed) begin
            n_row = (n_row == '0) ? ROW_MAX : n_row - 1'b1;
        end
        if (i_in_data.down_pressed) begin
            n_row = (n_row == ROW_MAX) ? '0 : n_row + 1'b1;
        end
        if (i_in_data.left_pressed) begin
            n_col = (n_col == '0) ? COL_MAX : n_col - 1'b1;
        end
        if (i_in_data.right_pressed) begin
            n_col = (n_col == COL_MAX) ? '0 : n_col + 1'b1;
        end
        n_page = PAGE_W'(n_row >> 3);
        n_idx  = ADDR_W'(ADDR_W'(n_page) * COLS_A) + ADDR_W'(n_col);
    end

    assign s1_data   = ram_rdata | (8'd1 << r_s1_bit);
    assign ram_we    = r_clr_active || r_s1_valid;
    assign ram_waddr = r_clr_active ? r_clr_addr : r_s1_idx;
    assign ram_wdata = r_clr_active ? 8'd0 : s1_data;

    cpp_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_xfer),
        .i_raddr (n_idx),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
            r_row        <= ROW_RST;
            r_col        <= COL_RST;
            r_s1_valid   <= 1'b0;
            r_pend_valid <= 1'b0;
            r_seq_valid  <= 1'b0;
            r_seq_cnt    <= 2'd0;
        end else begin
            if (r_clr_active) begin
                if (r_clr_addr == ADDR_MAX) begin
                    r_clr_active <= 1'b0;
                end else begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                end
            end
            if (in_xfer) begin
                r_row <= n_row;
                r_col <= n_col;
            end
            r_s1_valid <= in_xfer;
            if (r_s1_valid) begin
                r_pend_valid <= 1'b1;
            end else if (pend_move) begin
                r_pend_valid <= 1'b0;
            end
            if (pend_move) begin
                r_seq_valid <= 1'b1;
                r_seq_cnt   <= 2'd0;
            end else if (out_xfer) begin
                r_seq_cnt <= r_seq_cnt + 1'b1;
                if (r_seq_cnt == 2'd3) begin
                    r_seq_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_idx  <= n_idx;
            r_s1_bit  <= n_row[2:0];
            r_s1_page <= n_page;
            r_s1_addr <= 8'(n_col) + r_column_offset;
        end
        if (r_s1_valid) begin
            r_pend_bytes[0] <= r_page_base | 8'(r_s1_page);
            r_pend_bytes[1] <= r_col_low_base | {4'd0, r_s1_addr[3:0]};
            r_pend_bytes[2] <= r_col_high_base | {4'd0, r_s1_addr[7:4]};
            r_pend_bytes[3] <= s1_data;
        end
        if (pend_move) begin
            r_seq_bytes <= r_pend_bytes;
        end
    end

    assign o_out_valid         = r_seq_valid;
    assign o_out_data.is_data  = (r_seq_cnt == 2'd3);
    assign o_out_data.lcd_byte = r_seq_bytes[r_seq_cnt];
    assign o_out_data.last     = (r_seq_cnt == 2'd3);

endmodule

// File: rtl/core/cpp_ram.sv
// ----------------------------------------------------------------------------
// cpp_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cpp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: tb/lcd_stream_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lcd_stream_checker
// Watches the button, LCD byte and APB ports of the cursor pixel plotter.
// Keeps its own cursor, frame store and register copies, and predicts the
// four LCD bytes of every accepted button transfer. Each byte leaving the
// block is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module lcd_stream_checker
    import cpp_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  t_in_item                  i_in_data,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  t_out_item                 i_out_data,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [CPP_APB_ADDR_W-1:0] paddr,
    input  logic [CPP_APB_DATA_W-1:0] pwdata,
    input  logic                      pready,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_bytes_checked
);

    localparam int ROWS = CPP_PAGES * 8;
    localparam int COLS = CPP_COLUMNS;

    logic [7:0] col_offset;
    logic [7:0] page_base;
    logic [7:0] col_low_base;
    logic [7:0] col_high_base;

    int         cursor_row;
    int         cursor_col;
    logic [7:0] frame_mem [CPP_PAGES * CPP_COLUMNS];
    t_out_item  lcd_bytes_q [$];

    function automatic t_out_item lcd_item(logic is_data, logic [7:0] value, logic fin);
        t_out_item item;
        item.is_data  = is_data;
        item.lcd_byte = value;
        item.last     = fin;
        return item;
    endfunction

    // Move cursor, set its pixel, queue page/col-low/col-high/data bytes
    function automatic void plot_pixel(t_in_item ev);
        int         page;
        int         bit_pos;
        int         idx;
        logic [7:0] pix;
        logic [7:0] col_addr;
        if (ev.up_pressed)    cursor_row = (cursor_row + ROWS - 1) % ROWS;
        if (ev.down_pressed)  cursor_row = (cursor_row + 1) % ROWS;
        if (ev.left_pressed)  cursor_col = (cursor_col + COLS - 1) % COLS;
        if (ev.right_pressed) cursor_col = (cursor_col + 1) % COLS;
        page     = cursor_row / 8;
        bit_pos  = cursor_row % 8;
        idx      = page * COLS + cursor_col;
        pix      = frame_mem[idx] | (8'd1 << bit_pos);
        frame_mem[idx] = pix;
        col_addr = 8'(cursor_col + int'(col_offset));
        lcd_bytes_q.push_back(lcd_item(1'b0, page_base | 8'(page), 1'b0));
        lcd_bytes_q.push_back(lcd_item(1'b0, col_low_base | {4'h0, col_addr[3:0]}, 1'b0));
        lcd_bytes_q.push_back(lcd_item(1'b0, col_high_base | {4'h0, col_addr[7:4]}, 1'b0));
        lcd_bytes_q.push_back(lcd_item(1'b1, pix, 1'b1));
    endfunction

    always @(posedge i_clk) begin
        t_out_item exp_item;
        if (!i_rst_n) begin
            col_offset    = CPP_COLUMN_OFFSET_RST;
            page_base     = CPP_PAGE_BASE_RST;
            col_low_base  = CPP_COL_LOW_BASE_RST;
            col_high_base = CPP_COL_HIGH_BASE_RST;
            cursor_row    = int'(CPP_START_ROW_RST) % ROWS;
            cursor_col    = int'(CPP_START_COLUMN_RST) % COLS;
            foreach (frame_mem[k]) frame_mem[k] = 8'h00;
            lcd_bytes_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[CPP_APB_ADDR_W-1:2]))
                    REG_COLUMN_OFFSET: col_offset    = pwdata[7:0];
                    REG_PAGE_BASE:     page_base     = pwdata[7:0];
                    REG_COL_LOW_BASE:  col_low_base  = pwdata[7:0];
                    REG_COL_HIGH_BASE: col_high_base = pwdata[7:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) plot_pixel(i_in_data);
            if (i_out_valid && i_out_ready) begin
                o_bytes_checked++;
                if (lcd_bytes_q.size() == 0) begin
                    $display("%0t: unexpected LCD transfer is_data=%0d lcd_byte=%02h last=%0d",
                             $time, i_out_data.is_data, i_out_data.lcd_byte, i_out_data.last);
                    o_fail_count++;
                end else begin
                    exp_item = lcd_bytes_q.pop_front();
                    if (i_out_data.is_data !== exp_item.is_data ||
                        i_out_data.lcd_byte !== exp_item.lcd_byte ||
                        i_out_data.last !== exp_item.last) begin
                        $display("%0t: LCD mismatch expected is_data=%0d lcd_byte=%02h last=%0d",
                                 $time, exp_item.is_data, exp_item.lcd_byte, exp_item.last);
                        $display("%0t:              actual   is_data=%0d lcd_byte=%02h last=%0d",
                                 $time, i_out_data.is_data, i_out_data.lcd_byte,
                                 i_out_data.last);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = lcd_bytes_q.size();
    end

endmodule

// File: tb/tb_cursor_pixel_plotter_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cursor_pixel_plotter_top
// Drives button events and APB register writes into the plotter and gives
// the verdict. A directed pass walks every button combination; random
// events then drift the cursor up and right, across the row wrap point, under
// four idling profiles and several register settings, extremes included.
// ----------------------------------------------------------------------------
module tb_cursor_pixel_plotter_top;
    import cpp_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int EVENTS_PER_PASS = 23;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    t_in_item                  in_data;
    logic                      out_valid;
    logic                      out_ready;
    t_out_item                 out_data;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [CPP_APB_ADDR_W-1:0] paddr;
    logic [CPP_APB_DATA_W-1:0] pwdata;
    logic [CPP_APB_DATA_W-1:0] prdata;
    logic                      pready;

    int fail_count;
    int pending;
    int bytes_checked;
    int send_idle_pct;
    int recv_stall_pct;
    int events_sent;
    int settings_applied;
    int cycles;

    always #5 clk = ~clk;

    cursor_pixel_plotter_top uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    lcd_stream_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_in_data       (in_data),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_out_data      (out_data),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_bytes_checked (bytes_checked)
    );

    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d LCD bytes still expected", cycles, pending);
            $display("FAILURE");
            $finish;
        end
    end

    // Called and returns at a falling edge
    task automatic push_event(input t_in_item ev);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= ev;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        events_sent++;
    endtask

    // Leaves psel high so back-to-back writes assign it once per step
    task automatic write_reg(input t_reg_idx r, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CPP_APB_ADDR_W'({r, 2'b00});
        pwdata  <= CPP_APB_DATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
    endtask

    task automatic apply_settings(input logic [7:0] offset, input logic [7:0] page_cmd,
                                  input logic [7:0] low_cmd, input logic [7:0] high_cmd,
                                  input logic [5:0] row0, input logic [6:0] col0);
        write_reg(REG_COLUMN_OFFSET, offset);
        write_reg(REG_PAGE_BASE, page_cmd);
        write_reg(REG_COL_LOW_BASE, low_cmd);
        write_reg(REG_COL_HIGH_BASE, high_cmd);
        write_reg(REG_START_ROW, {2'b00, row0});
        write_reg(REG_START_COLUMN, {1'b0, col0});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        settings_applied++;
    endtask

    task automatic wait_drained();
        while (pending != 0) @(negedge clk);
    endtask

    // Mostly up+right so the cursor drifts toward both wrap points; some noise
    function automatic t_in_item drift_event();
        t_in_item ev;
        if ($urandom_range(99) < 20) begin
            ev = t_in_item'(4'($urandom_range(15)));
        end else begin
            ev.up_pressed    = ($urandom_range(99) < 85);
            ev.down_pressed  = ($urandom_range(99) < 12);
            ev.left_pressed  = ($urandom_range(99) < 12);
            ev.right_pressed = ($urandom_range(99) < 85);
        end
        return ev;
    endfunction

    initial begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        out_ready      = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: every button combination, then idle repeats of the same pixel
        apply_settings(8'd250, 8'd0, 8'd0, 8'd0, 6'd63, 7'd127);
        for (int k = 0; k < 16; k++) push_event(t_in_item'(4'(k)));
        push_event('0);
        push_event('0);
        in_valid <= 1'b0;
        wait_drained();

        for (int pass = 0; pass < 4; pass++) begin
            case (pass)
                0: begin
                    send_idle_pct = 0;  recv_stall_pct = 0;
                    apply_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                                   6'($urandom_range(63)), 7'($urandom_range(127)));
                end
                1: begin
                    send_idle_pct = 76; recv_stall_pct = 0;
                    apply_settings(8'd0, 8'd255, 8'd255, 8'd255, 6'd0, 7'd0);
                end
                2: begin
                    send_idle_pct = 0;  recv_stall_pct = 76;
                    apply_settings(CPP_COLUMN_OFFSET_RST, CPP_PAGE_BASE_RST,
                                   CPP_COL_LOW_BASE_RST, CPP_COL_HIGH_BASE_RST,
                                   CPP_START_ROW_RST, CPP_START_COLUMN_RST);
                end
                default: begin
                    send_idle_pct = 7;  recv_stall_pct = 7;
                    apply_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                                   6'($urandom_range(63)), 7'($urandom_range(127)));
                end
            endcase
            for (int n = 0; n < EVENTS_PER_PASS; n++) push_event(drift_event());
            in_valid <= 1'b0;
            wait_drained();
        end

        repeat (20) @(negedge clk);
        $display("Covered %0d button events and %0d LCD bytes over %0d register settings,",
                 events_sent, bytes_checked, settings_applied);
        $display("with no idling, a slow sender, a stalling receiver and light idling on both.");
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
